/* hdl/tlse_pkg.sv */
package tlse_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int HW_BITS     = 15;

  // coordinate difference, output and root widths
  localparam int CW      = SAMPLE_BITS + 1;
  localparam int OUT_W   = SAMPLE_BITS + 1;
  localparam int LEN_W   = SAMPLE_BITS + 1;
  localparam int RAD_W   = 2 * LEN_W;
  localparam int PROD_W  = SAMPLE_BITS + HW_BITS;
  localparam int NUM_W   = PROD_W + 1;
  localparam int DEN_W   = LEN_W + 1;
  localparam int QUO_W   = HW_BITS;
  localparam int OFS_W   = HW_BITS + 1;
  localparam int SUM_W   = ((SAMPLE_BITS > HW_BITS) ? SAMPLE_BITS : HW_BITS) + 2;
  localparam int CMP_W   = (LEN_W > HW_BITS) ? LEN_W : HW_BITS;
  localparam int STEP_MAX = (LEN_W > QUO_W) ? LEN_W : QUO_W;
  localparam int CNT_W   = $clog2(STEP_MAX + 1);

  // register file
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MONO_MODE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_LENGTH = 2'd3;

  // vertex order: p0-o, p0+o, p1-o, p0+o, p1-o, p1+o
  localparam int          VTX_COUNT   = 6;
  localparam logic [2:0]  VTX_LAST    = 3'd5;
  localparam logic [5:0]  VTX_FROM_P1 = 6'b110100;
  localparam logic [5:0]  VTX_ADD_OFS = 6'b101010;

  typedef struct packed {
    logic                enable;
    logic                mono_mode;
    logic [HW_BITS-1:0]  half_width;
    logic [HW_BITS-1:0]  min_length;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       new_seg;
    logic       sq;
    logic       root_ld;
    logic       root_step;
    logic       mul;
    logic       div_ld;
    logic       div_step;
    logic       div_store;
    logic       div_axis;
    logic       out_load;
    logic [2:0] vtx;
  } cmd_t;

  typedef struct packed {
    logic short_seg;
    logic out_free;
  } sts_t;

endpackage

/* hdl/tlse_in_if.sv */
interface tlse_in_if;
  import tlse_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] x_sample;
  logic signed [SAMPLE_BITS-1:0] y_sample;
  logic                          restart;

  modport source (output valid, x_sample, y_sample, restart, input ready);
  modport sink   (input valid, x_sample, y_sample, restart, output ready);
endinterface

/* hdl/tlse_out_if.sv */
interface tlse_out_if;
  import tlse_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] vertex_x;
  logic signed [OUT_W-1:0] vertex_y;
  logic                    last;

  modport source (output valid, vertex_x, vertex_y, last, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last, output ready);
endinterface

/* hdl/tlse_cfg.sv */
module tlse_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlse_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tlse_pkg::cfg_t              cfg
);
  import tlse_pkg::*;

  localparam logic [HW_BITS-1:0] HALF_WIDTH_RST = 15'd128;
  localparam logic [HW_BITS-1:0] MIN_LENGTH_RST = 15'd3;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_ENABLE:     cfg_nxt.enable     = pwdata[0];
        REG_MONO_MODE:  cfg_nxt.mono_mode  = pwdata[0];
        REG_HALF_WIDTH: cfg_nxt.half_width = pwdata[HW_BITS-1:0];
        REG_MIN_LENGTH: cfg_nxt.min_length = pwdata[HW_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE:     prdata = 32'(cfg_r.enable);
      REG_MONO_MODE:  prdata = 32'(cfg_r.mono_mode);
      REG_HALF_WIDTH: prdata = 32'(cfg_r.half_width);
      REG_MIN_LENGTH: prdata = 32'(cfg_r.min_length);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable     <= 1'b1;
      cfg_r.mono_mode  <= 1'b0;
      cfg_r.half_width <= HALF_WIDTH_RST;
      cfg_r.min_length <= MIN_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hdl/tlse_ctrl.sv */
module tlse_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  tlse_pkg::cfg_t cfg,
  input  logic           in_valid,
  input  logic           in_restart,
  output logic           in_ready,
  input  tlse_pkg::sts_t sts,
  output tlse_pkg::cmd_t cmd
);
  import tlse_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SQ      = 4'd1;
  localparam logic [3:0] S_ROOT_LD = 4'd2;
  localparam logic [3:0] S_ROOT    = 4'd3;
  localparam logic [3:0] S_CHK     = 4'd4;
  localparam logic [3:0] S_DIV_LD  = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_DIV_END = 4'd7;
  localparam logic [3:0] S_EMIT    = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       vtx_r, vtx_nxt;
  logic             axis_r, axis_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic             in_xfer;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    vtx_nxt       = vtx_r;
    axis_nxt      = axis_r;
    have_prev_nxt = have_prev_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && cfg.enable) begin
          cmd.accept    = 1'b1;
          have_prev_nxt = 1'b1;
          if (!in_restart && have_prev_r) begin
            cmd.new_seg = 1'b1;
            state_nxt   = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_ROOT_LD;
      end
      S_ROOT_LD: begin
        cmd.root_ld = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == CNT_W'(LEN_W - 1)) begin
          state_nxt = S_CHK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_CHK: begin
        // drop short segments; the point is already stored
        if (sts.short_seg) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.mul   = 1'b1;
          axis_nxt  = 1'b0;
          state_nxt = S_DIV_LD;
        end
      end
      S_DIV_LD: begin
        cmd.div_ld = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          state_nxt = S_DIV_END;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV_END: begin
        cmd.div_store = 1'b1;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = S_DIV_LD;
        end else begin
          vtx_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (vtx_r == VTX_LAST) begin
            state_nxt = S_IDLE;
          end else begin
            vtx_nxt = vtx_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.div_axis = axis_r;
    cmd.vtx      = vtx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      vtx_r       <= '0;
      axis_r      <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      vtx_r       <= vtx_nxt;
      axis_r      <= axis_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("vertex loaded into a full output register");

  a_seg_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && cfg.enable && !in_restart && have_prev_r) |=> (state_r == S_SQ))
    else $error("segment point did not start the length computation");

  a_emit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_END && axis_r) |=> (state_r == S_EMIT && vtx_r == 3'd0))
    else $error("emission did not start at the first vertex");

endmodule

/* hdl/tlse_dpath.sv */
module tlse_dpath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  tlse_pkg::cfg_t                          cfg,
  input  tlse_pkg::cmd_t                          cmd,
  output tlse_pkg::sts_t                          sts,
  input  logic signed [tlse_pkg::SAMPLE_BITS-1:0] x_sample,
  input  logic signed [tlse_pkg::SAMPLE_BITS-1:0] y_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [tlse_pkg::OUT_W-1:0]       vertex_x,
  output logic signed [tlse_pkg::OUT_W-1:0]       vertex_y,
  output logic                                    last
);
  import tlse_pkg::*;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-OUT_W:0] hi;
    hi = v[SUM_W-1:OUT_W-1];
    if ((&hi) || !(|hi)) begin
      return v[OUT_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  logic signed [SAMPLE_BITS-1:0] p0x_r, p0y_r, p1x_r, p1y_r;
  logic signed [SAMPLE_BITS-1:0] new_y;
  logic signed [CW-1:0]          dx_r, dy_r;
  logic [SAMPLE_BITS-1:0]        adx_r, ady_r;
  logic [RAD_W-1:0]              sqx, sqy, sqx_r, sqy_r;
  logic [RAD_W-1:0]              rad_r;
  logic [LEN_W+1:0]              rem_r;
  logic [LEN_W-1:0]              root_r;
  logic [LEN_W+3:0]              rt_cur, rt_try;
  logic [PROD_W-1:0]             prodx_r, prody_r;
  logic [NUM_W-1:0]              num;
  logic [QUO_W-1:0]              dnum_r, quo_r;
  logic [DEN_W-1:0]              drem_r;
  logic [DEN_W:0]                dv_cur, dv_den;
  logic                          neg;
  logic signed [OFS_W-1:0]       qmag, ofs;
  logic signed [OFS_W-1:0]       ofsx_r, ofsy_r;
  logic signed [SAMPLE_BITS-1:0] base_x, base_y;
  logic signed [SUM_W-1:0]       sum_x, sum_y;
  logic                          out_valid_r;
  logic signed [OUT_W-1:0]       vx_r, vy_r;
  logic                          last_r;

  assign new_y = cfg.mono_mode ? x_sample : y_sample;

  assign sqx = RAD_W'(dx_r) * RAD_W'(dx_r);
  assign sqy = RAD_W'(dy_r) * RAD_W'(dy_r);

  // one result bit per step of the square root
  assign rt_cur = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign rt_try = {2'b00, root_r, 2'b01};

  // numerator 2*mag*hw + len over denominator 2*len rounds to nearest
  assign num    = {(cmd.div_axis ? prody_r : prodx_r), 1'b0} + NUM_W'(root_r);
  assign dv_cur = {drem_r, dnum_r[QUO_W-1]};
  assign dv_den = {1'b0, root_r, 1'b0};

  // x offset follows -dy, y offset follows dx
  assign neg  = cmd.div_axis ? dx_r[CW-1] : (!dy_r[CW-1] && (dy_r != '0));
  assign qmag = OFS_W'(quo_r);
  assign ofs  = neg ? -qmag : qmag;

  assign base_x = VTX_FROM_P1[cmd.vtx] ? p1x_r : p0x_r;
  assign base_y = VTX_FROM_P1[cmd.vtx] ? p1y_r : p0y_r;
  assign sum_x  = VTX_ADD_OFS[cmd.vtx] ? SUM_W'(base_x) + SUM_W'(ofsx_r)
                                       : SUM_W'(base_x) - SUM_W'(ofsx_r);
  assign sum_y  = VTX_ADD_OFS[cmd.vtx] ? SUM_W'(base_y) + SUM_W'(ofsy_r)
                                       : SUM_W'(base_y) - SUM_W'(ofsy_r);

  assign sts.short_seg = (root_r == '0) || (CMP_W'(root_r) < CMP_W'(cfg.min_length));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign vertex_x  = vx_r;
  assign vertex_y  = vy_r;
  assign last      = last_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p1x_r <= x_sample;
      p1y_r <= new_y;
      if (cmd.new_seg) begin
        p0x_r <= p1x_r;
        p0y_r <= p1y_r;
        dx_r  <= CW'(x_sample) - CW'(p1x_r);
        dy_r  <= CW'(new_y) - CW'(p1y_r);
      end
    end
    if (cmd.sq) begin
      sqx_r <= sqx;
      sqy_r <= sqy;
      adx_r <= dx_r[CW-1] ? SAMPLE_BITS'(-dx_r) : SAMPLE_BITS'(dx_r);
      ady_r <= dy_r[CW-1] ? SAMPLE_BITS'(-dy_r) : SAMPLE_BITS'(dy_r);
    end
    if (cmd.root_ld) begin
      rad_r  <= sqx_r + sqy_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (rt_cur >= rt_try) begin
        rem_r  <= (LEN_W+2)'(rt_cur - rt_try);
        root_r <= {root_r[LEN_W-2:0], 1'b1};
      end else begin
        rem_r  <= rt_cur[LEN_W+1:0];
        root_r <= {root_r[LEN_W-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      prodx_r <= PROD_W'(ady_r) * PROD_W'(cfg.half_width);
      prody_r <= PROD_W'(adx_r) * PROD_W'(cfg.half_width);
    end
    if (cmd.div_ld) begin
      // the quotient never exceeds half_width, so the top part starts below the divisor
      drem_r <= DEN_W'(num[NUM_W-1:QUO_W]);
      dnum_r <= num[QUO_W-1:0];
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      dnum_r <= {dnum_r[QUO_W-2:0], 1'b0};
      if (dv_cur >= dv_den) begin
        drem_r <= DEN_W'(dv_cur - dv_den);
        quo_r  <= {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        drem_r <= dv_cur[DEN_W-1:0];
        quo_r  <= {quo_r[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd.div_store) begin
      if (cmd.div_axis) begin
        ofsy_r <= ofs;
      end else begin
        ofsx_r <= ofs;
      end
    end
    if (cmd.out_load) begin
      vx_r   <= sat_out(sum_x);
      vy_r   <= sat_out(sum_y);
      last_r <= (cmd.vtx == VTX_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  a_ofs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_store |-> (quo_r <= cfg.half_width))
    else $error("offset magnitude exceeds half width");

endmodule

/* hdl/thick_line_segment_expander_top.sv */
// Channel   Dir  Handshake        Payload
// in_ch     in   valid / ready    x_sample, y_sample, restart
// out_ch    out  valid / ready    vertex_x, vertex_y, last
// cfg       in   APB, pready = 1  enable, mono_mode, half_width, min_length
//
// A segment point passes the one-bit-per-cycle square root, then the shared
// restoring divider once per axis, then six vertex transfers through a single
// output register, which out_ch can stall. First, restart and disabled points
// stay in the idle state; short segments are dropped after the length check.
// Reset is synchronous, active low. A stalled out_ch holds the vertex and
// the controller; in_ch is ready again once the last vertex is loaded.
module thick_line_segment_expander_top (
  input  logic                        clk,
  input  logic                        rst_n,
  tlse_in_if.sink                     in_ch,
  tlse_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlse_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tlse_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  tlse_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tlse_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .x_sample  (in_ch.x_sample),
    .y_sample  (in_ch.y_sample),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .vertex_x  (out_ch.vertex_x),
    .vertex_y  (out_ch.vertex_y),
    .last      (out_ch.last)
  );

endmodule
